FILE: src/one_shot_frame_block_table_unit_defines.svh
// Assertion helpers for the one-shot frame block table.
`ifndef ONE_SHOT_FRAME_BLOCK_TABLE_UNIT_DEFINES_SVH
`define ONE_SHOT_FRAME_BLOCK_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OSFBT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("osfbt: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define OSFBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("osfbt: next-cycle check failed");

`endif

FILE: src/osfbt_pkg.sv
`default_nettype none

package osfbt_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 16;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   localparam int unsigned USED_W = 5;

   typedef struct packed {
      logic        opcode;
      logic [31:0] frame_id;
      logic [3:0]  length_code;
      logic [63:0] frame_data;
   } item_type;

   typedef struct packed {
      logic [31:0] ident;
      logic [3:0]  length;
      logic [63:0] bytes;
   } entry_type;

   typedef struct packed {
      logic              blocked;
      logic              status;
      logic [USED_W-1:0] entries_used;
   } res_type;

   function automatic int unsigned idx_width(int unsigned depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   function automatic int unsigned cnt_width(int unsigned depth);
      return $clog2(depth + 1);
   endfunction

   // Bytes at or above the length code are don't-care; codes above eight keep all bytes.
   function automatic logic [63:0] byte_mask(logic [3:0] len);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         m[8*b +: 8] = (len > 4'(b)) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

   function automatic logic entry_match(entry_type e, item_type it);
      return (e.ident == it.frame_id) && (e.length == it.length_code) &&
             (((e.bytes ^ it.frame_data) & byte_mask(it.length_code)) == 64'd0);
   endfunction

endpackage

`default_nettype wire

FILE: src/osfbt_req_if.sv
`default_nettype none

interface osfbt_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] frame_id;
   logic [3:0]  length_code;
   logic [63:0] frame_data;

   modport source (output valid, output opcode, output frame_id, output length_code,
                   output frame_data, input ready);
   modport sink   (input valid, input opcode, input frame_id, input length_code,
                   input frame_data, output ready);
endinterface

`default_nettype wire

FILE: src/osfbt_rsp_if.sv
`default_nettype none

interface osfbt_rsp_if;
   logic       valid;
   logic       ready;
   logic       blocked;
   logic       status;
   logic [4:0] entries_used;

   modport source (output valid, output blocked, output status, output entries_used,
                   input ready);
   modport sink   (input valid, input blocked, input status, input entries_used,
                   output ready);
endinterface

`default_nettype wire

FILE: src/osfbt_ram.sv
`default_nettype none

module osfbt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [osfbt_pkg::idx_width(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [osfbt_pkg::idx_width(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/osfbt_ctrl.sv
`default_nettype none

module osfbt_ctrl #(
   parameter int unsigned TABLE_DEPTH = osfbt_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         start,
   input  wire osfbt_pkg::item_type                          item,
   output logic                                              idle,
   output logic                                              res_valid,
   output osfbt_pkg::res_type                                res,
   input  wire logic                                         res_take,
   output logic                                              ram_wr_en,
   output logic      [osfbt_pkg::idx_width(TABLE_DEPTH)-1:0] ram_wr_addr,
   output osfbt_pkg::entry_type                              ram_wr_data,
   output logic                                              ram_rd_en,
   output logic      [osfbt_pkg::idx_width(TABLE_DEPTH)-1:0] ram_rd_addr,
   input  wire osfbt_pkg::entry_type                         ram_rd_data
);
   import osfbt_pkg::*;

   localparam int unsigned IDX_W = idx_width(TABLE_DEPTH);
   localparam int unsigned CNT_W = cnt_width(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   state_type              state_ff, state_in;
   item_type               item_ff, item_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   issue_ff, issue_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       used_ff, used_in;
   logic                   blocked_ff, blocked_in;
   logic                   status_ff, status_in;
   logic                   hit;

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      idx_in     = idx_ff;
      issue_in   = issue_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      valid_in   = valid_ff;
      used_in    = used_ff;
      blocked_in = blocked_ff;
      status_in  = status_ff;
      ram_wr_en  = 1'b0;
      ram_rd_en  = 1'b0;
      hit        = cmp_vld_ff && valid_ff[cmp_idx_ff] && entry_match(ram_rd_data, item_ff);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in  = item;
               idx_in   = '0;
               issue_in = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (item_ff.opcode == OP_ADD) begin
               // Take the lowest free entry; no table read needed.
               if (!valid_ff[idx_ff]) begin
                  ram_wr_en        = 1'b1;
                  valid_in[idx_ff] = 1'b1;
                  used_in          = CNT_W'(used_ff + 1'b1);
                  blocked_in       = 1'b0;
                  status_in        = STATUS_OK;
                  state_in         = ST_DONE;
               end else if (idx_ff == IDX_LAST) begin
                  blocked_in = 1'b0;
                  status_in  = STATUS_FULL;
                  state_in   = ST_DONE;
               end else begin
                  idx_in = IDX_W'(idx_ff + 1'b1);
               end
            end else begin
               if (hit) begin
                  valid_in[cmp_idx_ff] = 1'b0;
                  used_in              = CNT_W'(used_ff - 1'b1);
                  blocked_in           = 1'b1;
                  status_in            = STATUS_OK;
                  state_in             = ST_DONE;
               end else if (cmp_vld_ff && (cmp_idx_ff == IDX_LAST)) begin
                  blocked_in = 1'b0;
                  status_in  = STATUS_OK;
                  state_in   = ST_DONE;
               end else if (issue_ff) begin
                  ram_rd_en  = 1'b1;
                  cmp_vld_in = 1'b1;
                  cmp_idx_in = idx_ff;
                  if (idx_ff == IDX_LAST) begin
                     issue_in = 1'b0;
                  end else begin
                     idx_in = IDX_W'(idx_ff + 1'b1);
                  end
               end
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cmp_vld_ff <= 1'b0;
         issue_ff   <= 1'b0;
         valid_ff   <= '0;
         used_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         issue_ff   <= issue_in;
         valid_ff   <= valid_in;
         used_ff    <= used_in;
      end
      item_ff    <= item_in;
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      blocked_ff <= blocked_in;
      status_ff  <= status_in;
   end

   assign idle              = (state_ff == ST_IDLE);
   assign res_valid         = (state_ff == ST_DONE);
   assign res.blocked       = blocked_ff;
   assign res.status        = status_ff;
   assign res.entries_used  = USED_W'(used_ff);
   assign ram_wr_addr       = idx_ff;
   assign ram_rd_addr       = idx_ff;
   assign ram_wr_data.ident  = item_ff.frame_id;
   assign ram_wr_data.length = item_ff.length_code;
   assign ram_wr_data.bytes  = item_ff.frame_data;

endmodule

`default_nettype wire

FILE: src/one_shot_frame_block_table_unit.sv
// One-shot frame block table.
// req_chan carries one beat per item: opcode (add or check), frame_id, length_code and
// frame_data. rsp_chan returns exactly one beat per item, in order: blocked, status
// and entries_used (valid entries after the item, modulo 32).
// An add stores the frame in the lowest free entry or answers status full. A check
// compares the frame with the valid entries and drops the first one that matches.
// Timing: an add walks the valid bits one entry per cycle until it finds a free slot;
// a check reads the entry memory one entry per cycle (one read port, registered read
// data) and compares in the next cycle. The next request beat is taken in the cycle
// the response appears.
// Only one item is in flight, so table writes never overlap a later read.
// Reset clears all valid bits and the used count at once; entry contents need no clear.
// A stalled response holds in the output register; the next item may be accepted and
// scanned, and its result waits in the controller until the register frees up.
`default_nettype none

`include "one_shot_frame_block_table_unit_defines.svh"

module one_shot_frame_block_table_unit #(
   parameter int unsigned TABLE_DEPTH = osfbt_pkg::TABLE_DEPTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   osfbt_req_if.sink   req_chan,
   osfbt_rsp_if.source rsp_chan
);
   import osfbt_pkg::*;

   localparam int unsigned IDX_W = idx_width(TABLE_DEPTH);

   // Controller <-> entry memory
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   entry_type        ram_rd_data;

   // Controller handshake
   logic     ctrl_idle;
   logic     start;
   item_type item;
   logic     res_valid;
   res_type  res;
   logic     res_take;

   // Output register
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_res_ff;

   // Take a request beat only while no item is being worked on.
   assign req_chan.ready   = ctrl_idle;
   assign start            = req_chan.valid && req_chan.ready;
   assign item.opcode      = req_chan.opcode;
   assign item.frame_id    = req_chan.frame_id;
   assign item.length_code = req_chan.length_code;
   assign item.frame_data  = req_chan.frame_data;

   osfbt_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   osfbt_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .item        (item),
      .idle        (ctrl_idle),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (res_take),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // Advance the finished result into the output register when it is empty or draining.
   assign res_take = res_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the payload while stalled.
   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.blocked      = rsp_res_ff.blocked;
   assign rsp_chan.status       = rsp_res_ff.status;
   assign rsp_chan.entries_used = rsp_res_ff.entries_used;

   // A refused add means every entry was in use.
   `OSFBT_ASSERT_NOW(a_full_means_all_used, clock, reset,
                     rsp_valid_ff && (rsp_res_ff.status == STATUS_FULL),
                     rsp_res_ff.entries_used == USED_W'(TABLE_DEPTH))

   // An item never both blocks and gets refused.
   `OSFBT_ASSERT_NOW(a_blocked_excl_full, clock, reset,
                     rsp_valid_ff && rsp_res_ff.blocked,
                     rsp_res_ff.status == STATUS_OK)

   // A new request is never taken while a finished result is still pending.
   `OSFBT_ASSERT_NOW(a_no_accept_with_result, clock, reset, req_chan.ready, !res_valid)

   // A handed-over result is presented on the next cycle.
   `OSFBT_ASSERT_NEXT(a_take_shows_rsp, clock, reset, res_take, rsp_valid_ff)

endmodule

`default_nettype wire

FILE: tb/osfbt_table_checker.sv
`timescale 1ns / 100ps

module osfbt_table_checker
   import osfbt_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   osfbt_req_if      req_mon,
   osfbt_rsp_if      rsp_mon,
   output int        mismatch_count,
   output int        outstanding
);

   localparam int unsigned DEPTH = TABLE_DEPTH_DEF;

   logic        slot_live  [DEPTH];
   entry_type   slot_frame [DEPTH];
   int unsigned live_count;
   res_type     awaited_results [$];
   int          errors;

   initial begin
      errors         = 0;
      live_count     = 0;
      mismatch_count = 0;
      outstanding    = 0;
      for (int i = 0; i < DEPTH; i++) slot_live[i] = 1'b0;
   end

   // Add takes the lowest free slot; check drops the lowest live slot that matches.
   task automatic predict_frame(input item_type it, output res_type r);
      int          hit;
      logic [63:0] cmp_mask;
      hit      = -1;
      r        = '0;
      r.status = STATUS_OK;
      if (it.opcode == OP_ADD) begin
         for (int i = 0; i < DEPTH && hit < 0; i++)
            if (!slot_live[i]) hit = i;
         if (hit < 0) begin
            r.status = STATUS_FULL;
         end else begin
            slot_live[hit]  = 1'b1;
            slot_frame[hit] = {it.frame_id, it.length_code, it.frame_data};
            live_count++;
         end
      end else begin
         // codes above eight compare every byte
         cmp_mask = (it.length_code >= 4'd8) ? '1
                                             : (64'd1 << (8 * it.length_code)) - 64'd1;
         for (int i = 0; i < DEPTH && hit < 0; i++)
            if (slot_live[i] && slot_frame[i].ident == it.frame_id &&
                slot_frame[i].length == it.length_code &&
                ((slot_frame[i].bytes ^ it.frame_data) & cmp_mask) == 64'd0)
               hit = i;
         if (hit >= 0) begin
            slot_live[hit] = 1'b0;
            live_count--;
            r.blocked = 1'b1;
         end
      end
      r.entries_used = USED_W'(live_count);
   endtask

   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) slot_live[i] = 1'b0;
         live_count = 0;
         awaited_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_results.size() == 0) begin
               $error("response beat with nothing outstanding: blocked %0d status %0d used %0d",
                      rsp_mon.blocked, rsp_mon.status, rsp_mon.entries_used);
               errors++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_mon.blocked !== want.blocked) begin
                  $error("blocked: expected %0d, got %0d", want.blocked, rsp_mon.blocked);
                  errors++;
               end
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
                  errors++;
               end
               if (rsp_mon.entries_used !== want.entries_used) begin
                  $error("entries_used: expected %0d, got %0d",
                         want.entries_used, rsp_mon.entries_used);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_frame({req_mon.opcode, req_mon.frame_id, req_mon.length_code,
                           req_mon.frame_data}, want);
            awaited_results.push_back(want);
         end
      end
      mismatch_count <= errors;
      outstanding    <= awaited_results.size();
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import osfbt_pkg::*;

   logic clock;
   logic reset = 1'b1;
   int   fail_count;
   int   outstanding;

   osfbt_req_if req_chan ();
   osfbt_rsp_if rsp_chan ();

   one_shot_frame_block_table_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // The checker watches both channels, predicts every response and counts mismatches.
   osfbt_table_checker u_table_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (fail_count),
      .outstanding    (outstanding)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Frames recently added; checks draw from here so that most of them can hit.
   item_type    recent_frames [$];
   int unsigned sender_burst = 0;

   function automatic item_type frame_beat(logic op, logic [31:0] id, logic [3:0] len,
                                           logic [63:0] data);
      return {op, id, len, data};
   endfunction

   function automatic item_type random_frame(logic op);
      item_type f;
      f.opcode      = op;
      // a narrow id range now and then lets unrelated frames collide on the identifier
      f.frame_id    = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 3)) : 32'($urandom);
      // lengths past eight are legal on the wire, so mix a few in
      f.length_code = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(9, 15))
                                                  : 4'($urandom_range(0, 8));
      f.frame_data  = {$urandom, $urandom};
      return f;
   endfunction

   // Idle for a random gap, then hold the beat on the channel until it is taken.
   task automatic present_frame(input item_type it);
      int unsigned roll;
      int unsigned gap;
      if (sender_burst != 0) begin
         sender_burst--;
         gap = 0;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            // open a stretch of back-to-back beats
            sender_burst = $urandom_range(20, 60);
            gap = 0;
         end else if (roll < 50) begin
            gap = 0;
         end else if (roll < 85) begin
            gap = $urandom_range(1, 3);
         end else if (roll < 96) begin
            gap = $urandom_range(4, 12);
         end else begin
            gap = $urandom_range(20, 60);
         end
      end
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.opcode      <= it.opcode;
      req_chan.frame_id    <= it.frame_id;
      req_chan.length_code <= it.length_code;
      req_chan.frame_data  <= it.frame_data;
      do @(posedge clock); while (!req_chan.ready);
      if (it.opcode == OP_ADD) begin
         recent_frames.push_back(it);
         if (recent_frames.size() > 32) void'(recent_frames.pop_front());
      end
   endtask

   // Response side: random ready pattern, with long open stretches and two long hold-offs.
   initial begin
      int unsigned rounds;
      int unsigned roll;
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      rounds = 0;
      wait (!reset);
      forever begin
         rounds++;
         if (rounds == 120 || rounds == 600) begin
            // hold off long enough that the unit backs up and stalls the request side
            rsp_chan.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         roll = $urandom_range(0, 99);
         repeat ((roll < 8) ? $urandom_range(60, 200) : $urandom_range(1, 12))
            @(posedge clock);
         roll = $urandom_range(0, 99);
         stall = (roll < 40) ? 0 :
                 (roll < 85) ? $urandom_range(1, 3) :
                 (roll < 96) ? $urandom_range(4, 15) : $urandom_range(20, 60);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Request side: directed frames, then random traffic in fill, drain and mixed phases.
   initial begin
      item_type    pick;
      int unsigned phase;
      int unsigned phase_left;
      int unsigned add_share;
      int unsigned slot;
      int unsigned span;
      int unsigned roll;

      req_chan.valid       <= 1'b0;
      req_chan.opcode      <= OP_ADD;
      req_chan.frame_id    <= '0;
      req_chan.length_code <= '0;
      req_chan.frame_data  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty table: nothing to block
      present_frame(frame_beat(OP_CHECK, 32'h0, 4'd0, 64'h0));
      present_frame(frame_beat(OP_ADD, 32'hFFFF_FFFF, 4'd8, '1));
      present_frame(frame_beat(OP_ADD, 32'h0, 4'd0, 64'h0123_4567_89AB_CDEF));
      present_frame(frame_beat(OP_ADD, 32'h8000_0123, 4'd15, 64'hA5A5_5A5A_F00D_BEEF));
      present_frame(frame_beat(OP_ADD, 32'h0000_07FF, 4'd3, 64'h0));
      // bytes past the length code are not compared
      present_frame(frame_beat(OP_CHECK, 32'h0000_07FF, 4'd3, 64'hFFFF_FFFF_FF00_0000));
      // blocked once only: the same frame now passes
      present_frame(frame_beat(OP_CHECK, 32'h0000_07FF, 4'd3, 64'h0));
      // length code above eight compares all eight bytes
      present_frame(frame_beat(OP_CHECK, 32'h8000_0123, 4'd15, 64'hA5A5_5A5A_F00D_BEEE));
      present_frame(frame_beat(OP_CHECK, 32'h8000_0123, 4'd15, 64'hA5A5_5A5A_F00D_BEEF));
      // zero length ignores the data entirely
      present_frame(frame_beat(OP_CHECK, 32'h0, 4'd0, '1));
      // length code differs: no match
      present_frame(frame_beat(OP_CHECK, 32'hFFFF_FFFF, 4'd7, '1));
      // fill with duplicates, then one add that must be refused
      for (int i = 0; i < 16; i++)
         present_frame(frame_beat(OP_ADD, 32'h1234_5678, 4'd2, 64'h0000_BEEF));
      // duplicates go one per check
      present_frame(frame_beat(OP_CHECK, 32'h1234_5678, 4'd2, 64'h1111_BEEF));
      present_frame(frame_beat(OP_CHECK, 32'hFFFF_FFFF, 4'd8, '1));

      phase_left = 0;
      phase      = 0;
      for (int n = 0; n < 1450; n++) begin
         if (phase_left == 0) begin
            phase      = $urandom_range(0, 2);
            phase_left = $urandom_range(10, 40);
         end
         phase_left--;
         // fill phases push the table to full, drain phases empty it again
         add_share = (phase == 0) ? 75 : (phase == 1) ? 25 : 50;
         if ($urandom_range(0, 99) < add_share) begin
            if (recent_frames.size() != 0 && $urandom_range(0, 99) < 15) begin
               pick        = recent_frames[$urandom_range(0, recent_frames.size() - 1)];
               pick.opcode = OP_ADD;
            end else begin
               pick = random_frame(OP_ADD);
            end
         end else if (recent_frames.size() != 0 && $urandom_range(0, 99) < 80) begin
            slot        = $urandom_range(0, recent_frames.size() - 1);
            pick        = recent_frames[slot];
            pick.opcode = OP_CHECK;
            roll        = $urandom_range(0, 99);
            if (roll < 60) begin
               // expected hit: scramble the bytes past the length code
               if (pick.length_code < 4'd8)
                  pick.frame_data ^= {$urandom, $urandom} << (8 * pick.length_code);
               recent_frames.delete(slot);
            end else begin
               // near miss: disturb exactly one compared part
               span = (pick.length_code > 4'd8) ? 64 : 8 * pick.length_code;
               if (roll < 73 || span == 0) begin
                  pick.frame_id ^= 32'd1 << $urandom_range(0, 31);
               end else if (roll < 86) begin
                  pick.length_code ^= 4'($urandom_range(1, 15));
               end else begin
                  pick.frame_data ^= 64'd1 << $urandom_range(0, span - 1);
               end
            end
         end else begin
            pick = random_frame(OP_CHECK);
         end
         present_frame(pick);
      end
      req_chan.valid <= 1'b0;

      // let the last accepted beat reach the checker, drain, then watch for strays
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2 * TABLE_DEPTH_DEF + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
